// File: rtl/afsk_pkg.sv
// Shared types, constants and the sine lookup for the AFSK HDLC modulator.
// Used by every module of the block but afsk_ram; depends on nothing.
`timescale 1ns / 1ps

package afsk_pkg;

   // Register indexes on the configuration port
   localparam logic [2:0] REG_SPACE       = 3'd0;
   localparam logic [2:0] REG_MARK        = 3'd1;
   localparam logic [2:0] REG_BIT_STEP    = 3'd2;
   localparam logic [2:0] REG_SAMPLE_RATE = 3'd3;
   localparam logic [2:0] REG_START_FLAGS = 3'd4;
   localparam logic [2:0] REG_END_FLAGS   = 3'd5;

   // Action codes on the input channel
   localparam logic [1:0] ACT_LOAD  = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;
   localparam logic [1:0] ACT_TICK  = 2'd2;

   localparam logic [7:0] FLAG_BYTE = 8'h7E;
   localparam logic [2:0] RUN_LIMIT = 3'd5;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_START,
      OP_TICK
   } op_type;

   typedef enum logic [1:0] {
      STG_START = 2'd0,
      STG_DATA  = 2'd1,
      STG_END   = 2'd2,
      STG_DONE  = 2'd3
   } stage_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_ADV,
      BK_READ
   } back_state_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] byte_value;
   } item_type;

   typedef struct packed {
      logic [7:0]  phase_step_space;
      logic [7:0]  phase_step_mark;
      logic [15:0] bit_step;
      logic [15:0] sample_rate;
      logic [7:0]  start_flags;
      logic [7:0]  end_flags;
   } cfg_type;

   // First quadrant of the sine, 127 full scale
   localparam logic [6:0] QSINE [0:64] = '{
      7'd0,   7'd3,   7'd6,   7'd9,   7'd12,  7'd16,  7'd19,  7'd22,
      7'd25,  7'd28,  7'd31,  7'd34,  7'd37,  7'd40,  7'd43,  7'd46,
      7'd49,  7'd51,  7'd54,  7'd57,  7'd60,  7'd63,  7'd65,  7'd68,
      7'd71,  7'd73,  7'd76,  7'd78,  7'd81,  7'd83,  7'd85,  7'd88,
      7'd90,  7'd92,  7'd94,  7'd96,  7'd98,  7'd100, 7'd102, 7'd104,
      7'd106, 7'd107, 7'd109, 7'd111, 7'd112, 7'd113, 7'd115, 7'd116,
      7'd117, 7'd118, 7'd120, 7'd121, 7'd122, 7'd122, 7'd123, 7'd124,
      7'd125, 7'd125, 7'd126, 7'd126, 7'd126, 7'd127, 7'd127, 7'd127,
      7'd127
   };

   // Fold the phase into the first quadrant and restore the sign
   function automatic logic [7:0] sine_bits(input logic [7:0] p);
      logic [6:0] idx;
      logic [6:0] mag;
      idx = p[6] ? (7'd64 - {1'b0, p[5:0]}) : {1'b0, p[5:0]};
      mag = QSINE[idx];
      return p[7] ? (8'd0 - {1'b0, mag}) : {1'b0, mag};
   endfunction

endpackage

// File: rtl/afsk_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module afsk_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/afsk_csr.sv
// Configuration registers behind an APB-style port.
// Depends on afsk_pkg for the register indexes and the config struct.
`timescale 1ns / 1ps

module afsk_csr
   import afsk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[4:2];

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_SPACE:       cfg_in.phase_step_space = csr_pwdata[7:0];
            REG_MARK:        cfg_in.phase_step_mark  = csr_pwdata[7:0];
            REG_BIT_STEP:    cfg_in.bit_step         = csr_pwdata[15:0];
            REG_SAMPLE_RATE: cfg_in.sample_rate      = csr_pwdata[15:0];
            REG_START_FLAGS: cfg_in.start_flags      = csr_pwdata[7:0];
            REG_END_FLAGS:   cfg_in.end_flags        = csr_pwdata[7:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_step_space <= 8'd0;
         cfg_ff.phase_step_mark  <= 8'd0;
         cfg_ff.bit_step         <= 16'd1200;
         cfg_ff.sample_rate      <= 16'd9600;
         cfg_ff.start_flags      <= 8'd1;
         cfg_ff.end_flags        <= 8'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the selected register
   always_comb begin
      case (reg_idx)
         REG_SPACE:       csr_prdata = {24'd0, cfg_ff.phase_step_space};
         REG_MARK:        csr_prdata = {24'd0, cfg_ff.phase_step_mark};
         REG_BIT_STEP:    csr_prdata = {16'd0, cfg_ff.bit_step};
         REG_SAMPLE_RATE: csr_prdata = {16'd0, cfg_ff.sample_rate};
         REG_START_FLAGS: csr_prdata = {24'd0, cfg_ff.start_flags};
         REG_END_FLAGS:   csr_prdata = {24'd0, cfg_ff.end_flags};
         default:         csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/afsk_front.sv
// Input front end: accepts items, decodes the action and queues them.
// Depends on afsk_pkg for the item and op types.
`timescale 1ns / 1ps

module afsk_front
   import afsk_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  logic [7:0] req_tdata,  // [7:0] byte_value
   input  logic [1:0] req_tuser,  // [1:0] action
   output logic     q_valid,
   output item_type q_item,
   input  logic     q_pop
);

   item_type   slot_ff [0:1];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] fill_ff;
   logic [1:0] fill_in;
   logic       accept;
   logic       push;
   item_type   dec_item;
   logic       dec_keep;

   assign req_tready = (fill_ff != 2'd2);
   assign accept     = req_tvalid & req_tready;

   // Classify the action; drop unknown codes here
   always_comb begin
      dec_item.byte_value = req_tdata;
      dec_keep            = 1'b1;
      case (req_tuser)
         ACT_LOAD:  dec_item.op = OP_LOAD;
         ACT_START: dec_item.op = OP_START;
         ACT_TICK:  dec_item.op = OP_TICK;
         default: begin
            dec_item.op = OP_LOAD;
            dec_keep    = 1'b0;
         end
      endcase
   end

   assign push = accept & dec_keep;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Hold queued items
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= dec_item;
      end
   end

   assign q_valid = (fill_ff != 2'd0);
   assign q_item  = slot_ff[rd_ptr_ff];

endmodule

// File: rtl/afsk_back.sv
// Frame engine: packet buffer, HDLC bit sequencing with stuffing, NRZI tone,
// bit timing, phase accumulator and the result register.
// Depends on afsk_pkg and afsk_ram.
`timescale 1ns / 1ps

module afsk_back
   import afsk_pkg::*;
#(
   parameter int BUFFER_BYTES = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              q_valid,
   input  item_type          q_item,
   output logic              q_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic signed [7:0] rsp_tdata,  // [7:0] sample
   output logic              rsp_tuser   // [0] finished
);

   localparam int ADDR_W = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
   localparam int CNT_W  = $clog2(BUFFER_BYTES + 1);
   localparam int POS_W  = (CNT_W + 3 > 11) ? CNT_W + 3 : 11;

   back_state_type state_ff, state_in;
   stage_type      stage_ff, stage_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      timer_ff, timer_in;
   logic [2:0]       ones_ff, ones_in;
   logic             tone_ff, tone_in;
   logic [7:0]       phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       sample_ff, sample_in;
   logic             fin_ff, fin_in;

   logic             ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [ADDR_W-1:0] ram_raddr;
   logic [7:0]       ram_rdata;

   logic             out_free;
   logic [16:0]      t_sum;
   logic [16:0]      t_wrap;
   logic [16:0]      rate17;
   logic             boundary;
   logic [15:0]      timer_next;
   logic             flags_left;
   logic             data_left;
   logic             run_full;
   logic             flag_bit;
   logic             data_bit;
   logic             do_tick;

   afsk_ram #(
      .WIDTH (8),
      .DEPTH (BUFFER_BYTES)
   ) u_buf (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (q_item.byte_value),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign ram_waddr = count_ff[ADDR_W-1:0];
   assign ram_raddr = pos_ff[3 +: ADDR_W];

   // Bit timing: one boundary at most per tick, excess time clamped
   assign rate17   = {1'b0, cfg.sample_rate};
   assign t_sum    = {1'b0, timer_ff} + {1'b0, cfg.bit_step};
   assign t_wrap   = t_sum - rate17;
   assign boundary = (t_sum >= rate17);
   always_comb begin
      if (!boundary) begin
         timer_next = t_sum[15:0];
      end else if (t_wrap >= rate17) begin
         timer_next = (cfg.sample_rate != 16'd0) ? cfg.sample_rate - 16'd1 : 16'd0;
      end else begin
         timer_next = t_wrap[15:0];
      end
   end

   // Stage conditions
   always_comb begin
      if (stage_ff == STG_START) begin
         flags_left = pos_ff < POS_W'({cfg.start_flags, 3'b000});
      end else begin
         flags_left = pos_ff < POS_W'({cfg.end_flags, 3'b000});
      end
   end
   assign data_left = pos_ff < POS_W'({count_ff, 3'b000});
   assign run_full  = (ones_ff >= RUN_LIMIT);
   assign flag_bit  = FLAG_BYTE[pos_ff[2:0]];
   assign data_bit  = ram_rdata[pos_ff[2:0]];

   assign out_free = ~rsp_valid_ff | rsp_tready;
   assign do_tick  = q_valid & (q_item.op == OP_TICK) & out_free;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid && q_item.op == OP_START) begin
               state_in = BK_ADV;
            end else if (do_tick && stage_ff != STG_DONE && boundary) begin
               state_in = BK_ADV;
            end
         end
         BK_ADV: begin
            case (stage_ff)
               STG_START: state_in = flags_left ? BK_IDLE : BK_ADV;
               STG_END:   state_in = BK_IDLE;
               STG_DATA: begin
                  if (run_full) begin
                     state_in = BK_IDLE;
                  end else if (data_left) begin
                     state_in = BK_READ;
                  end else begin
                     state_in = BK_ADV;
                  end
               end
               default:   state_in = BK_IDLE;
            endcase
         end
         BK_READ: state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   // Datapath and queue control
   always_comb begin
      stage_in     = stage_ff;
      pos_in       = pos_ff;
      timer_in     = timer_ff;
      ones_in      = ones_ff;
      tone_in      = tone_ff;
      phase_in     = phase_ff;
      count_in     = count_ff;
      sample_in    = sample_ff;
      fin_in       = fin_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      q_pop        = 1'b0;
      ram_we       = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               case (q_item.op)
                  OP_LOAD: begin
                     q_pop = 1'b1;
                     if (count_ff < CNT_W'(BUFFER_BYTES)) begin
                        ram_we   = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_START: begin
                     q_pop    = 1'b1;
                     stage_in = STG_START;
                     pos_in   = '0;
                     timer_in = 16'd0;
                     ones_in  = 3'd0;
                     tone_in  = 1'b0;
                  end
                  OP_TICK: begin
                     if (out_free) begin
                        q_pop        = 1'b1;
                        rsp_valid_in = 1'b1;
                        if (stage_ff == STG_DONE) begin
                           sample_in = 8'd0;
                           fin_in    = 1'b1;
                        end else begin
                           phase_in  = phase_ff + (tone_ff ? cfg.phase_step_mark
                                                           : cfg.phase_step_space);
                           sample_in = sine_bits(phase_in);
                           fin_in    = 1'b0;
                           timer_in  = timer_next;
                        end
                     end
                  end
                  default: q_pop = 1'b1;
               endcase
            end
         end
         BK_ADV: begin
            case (stage_ff)
               STG_START, STG_END: begin
                  if (flags_left) begin
                     tone_in = flag_bit ? tone_ff : ~tone_ff;
                     pos_in  = pos_ff + POS_W'(1);
                  end else begin
                     pos_in  = '0;
                     ones_in = 3'd0;
                     if (stage_ff == STG_START) begin
                        stage_in = STG_DATA;
                     end else begin
                        stage_in = STG_DONE;
                        count_in = '0;
                     end
                  end
               end
               STG_DATA: begin
                  if (run_full) begin
                     // stuffed zero
                     tone_in = ~tone_ff;
                     ones_in = 3'd0;
                  end else if (!data_left) begin
                     pos_in   = '0;
                     ones_in  = 3'd0;
                     stage_in = STG_END;
                  end
               end
               default: stage_in = stage_ff;
            endcase
         end
         BK_READ: begin
            tone_in = data_bit ? tone_ff : ~tone_ff;
            ones_in = data_bit ? ones_ff + 3'd1 : 3'd0;
            pos_in  = pos_ff + POS_W'(1);
         end
         default: stage_in = stage_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         stage_ff     <= STG_DONE;
         pos_ff       <= '0;
         timer_ff     <= 16'd0;
         ones_ff      <= 3'd0;
         tone_ff      <= 1'b0;
         phase_ff     <= 8'd0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stage_ff     <= stage_in;
         pos_ff       <= pos_in;
         timer_ff     <= timer_in;
         ones_ff      <= ones_in;
         tone_ff      <= tone_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      fin_ff    <= fin_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = sample_ff;
   assign rsp_tuser  = fin_ff;

endmodule

// File: rtl/afsk_hdlc_nrzi_modulator.sv
// AFSK modulator with HDLC flags, bit stuffing and NRZI tone switching.
// A tick is held in a front-end queue slot; with the back end idle and the
// output free, its sample is then written to the result register.
// Throughput: one item per cycle for loads, and for plain ticks while the
// output is not stalled; a tick at a bit boundary and a start hold the queue
// while the sequencer steps stages one per cycle with a registered RAM read.
// Reset (synchronous): frame finished, buffer empty, config at defaults.
`timescale 1ns / 1ps

module afsk_hdlc_nrzi_modulator
   import afsk_pkg::*;
#(
   parameter int BUFFER_BYTES = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,  // [7:0] byte_value
   input  logic [1:0]        req_tuser,  // [1:0] action
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic signed [7:0] rsp_tdata,  // [7:0] sample
   output logic              rsp_tuser,  // [0] finished
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [4:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   cfg_type  cfg;
   logic     q_valid;
   item_type q_item;
   logic     q_pop;

   afsk_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   afsk_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   afsk_back #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: tb/tb_afsk_hdlc_nrzi_modulator.sv
// Self-checking testbench for the AFSK HDLC NRZI modulator: stream items in, samples out.
// Predicts each sample from its own copy of the framing state; depends on afsk_pkg.
`timescale 1ns / 1ps

module tb_afsk_hdlc_nrzi_modulator;
   import afsk_pkg::*;

   localparam int BUF_DEPTH    = 256;
   localparam int HALF_PERIOD  = 5;
   localparam int IDLE_PCT     = 36;
   localparam int QUIET_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SHOW_ERRORS  = 10;

   // Action code the block ignores
   localparam logic [1:0] ACT_NONE = 2'd3;

   // First quadrant of a 127 full-scale sine, 64 steps per quadrant
   localparam logic [6:0] QUARTER_WAVE [0:64] = '{
      7'd0,   7'd3,   7'd6,   7'd9,   7'd12,  7'd16,  7'd19,  7'd22,
      7'd25,  7'd28,  7'd31,  7'd34,  7'd37,  7'd40,  7'd43,  7'd46,
      7'd49,  7'd51,  7'd54,  7'd57,  7'd60,  7'd63,  7'd65,  7'd68,
      7'd71,  7'd73,  7'd76,  7'd78,  7'd81,  7'd83,  7'd85,  7'd88,
      7'd90,  7'd92,  7'd94,  7'd96,  7'd98,  7'd100, 7'd102, 7'd104,
      7'd106, 7'd107, 7'd109, 7'd111, 7'd112, 7'd113, 7'd115, 7'd116,
      7'd117, 7'd118, 7'd120, 7'd121, 7'd122, 7'd122, 7'd123, 7'd124,
      7'd125, 7'd125, 7'd126, 7'd126, 7'd126, 7'd127, 7'd127, 7'd127,
      7'd127
   };

   typedef enum logic {
      ENT_ITEM,
      ENT_WRITE
   } entry_kind_type;

   typedef struct packed {
      entry_kind_type kind;
      logic [1:0]     action;
      logic [7:0]     byte_value;
      logic [2:0]     reg_idx;
      logic [31:0]    value;
   } entry_type;

   typedef struct packed {
      logic [7:0] sample;
      logic       finished;
   } sample_exp_type;

   typedef enum logic [2:0] {
      DRV_FETCH,
      DRV_SETTLE,
      DRV_WSETUP,
      DRV_WACCESS,
      DRV_RSETUP,
      DRV_RACCESS
   } drv_state_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata   = '0;  // [7:0] byte_value
   logic [1:0]        req_tuser   = '0;  // [1:0] action
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic signed [7:0] rsp_tdata;         // [7:0] sample
   logic              rsp_tuser;         // [0] finished
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [4:0]        csr_paddr   = '0;
   logic [31:0]       csr_pwdata  = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   afsk_hdlc_nrzi_modulator #(
      .BUFFER_BYTES(BUF_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Modulator copy: configuration and framing state
   cfg_type    cfg;
   logic [7:0] pkt_mem [0:BUF_DEPTH-1];
   int         pkt_fill;
   stage_type  stage;
   int         bit_pos;
   int         bit_timer;
   int         ones_run;
   logic       tone;
   logic [7:0] phase;

   entry_type      pending_items [$];
   sample_exp_type due_samples [$];

   drv_state_type  drv_state = DRV_FETCH;
   entry_type      cur_item;
   entry_type      wr_entry;
   logic           slot_free;
   logic           stim_done = 1'b0;
   logic           calm;
   int             quiet_count = 0;
   int             accepted_items = 0;
   int             error_count = 0;
   int             cycle_count = 0;
   sample_exp_type got_exp;

   // Stimulus planning: rough view of the configuration for frame lengths
   int plan_br;
   int plan_sr;
   int plan_sf;
   int plan_ef;
   int plan_fill;
   int item_total;

   assign calm = (accepted_items >= 500) && (accepted_items < 800);

   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= SHOW_ERRORS) $display("%s", msg);
   endtask

   function automatic logic [7:0] tone_sample(input logic [7:0] p);
      int         q;
      logic [6:0] mag;
      q = int'(p[5:0]);
      mag = p[6] ? QUARTER_WAVE[64 - q] : QUARTER_WAVE[q];
      return p[7] ? 8'(8'd0 - {1'b0, mag}) : {1'b0, mag};
   endfunction

   // Apply the next frame bit, skipping stages that have nothing left to send
   task automatic next_frame_bit();
      int   n;
      logic bit_val;
      logic done;
      done = 1'b0;
      while (!done) begin
         case (stage)
            STG_START, STG_END: begin
               n = (stage == STG_START) ? int'(cfg.start_flags) : int'(cfg.end_flags);
               if (bit_pos < n * 8) begin
                  if (!FLAG_BYTE[bit_pos & 7]) tone = ~tone;
                  bit_pos++;
                  done = 1'b1;
               end else begin
                  bit_pos  = 0;
                  ones_run = 0;
                  if (stage == STG_START) begin
                     stage = STG_DATA;
                  end else begin
                     stage    = STG_DONE;
                     pkt_fill = 0;
                     done     = 1'b1;
                  end
               end
            end
            STG_DATA: begin
               if (ones_run >= RUN_LIMIT) begin
                  // stuffed zero after five ones
                  tone     = ~tone;
                  ones_run = 0;
                  done     = 1'b1;
               end else if (bit_pos < pkt_fill * 8) begin
                  bit_val = pkt_mem[bit_pos >> 3][bit_pos & 7];
                  if (!bit_val) tone = ~tone;
                  ones_run = bit_val ? ones_run + 1 : 0;
                  bit_pos++;
                  done = 1'b1;
               end else begin
                  bit_pos  = 0;
                  ones_run = 0;
                  stage    = STG_END;
               end
            end
            default: done = 1'b1;
         endcase
      end
   endtask

   // Advance the modulator copy by one accepted item and queue the sample of a tick
   task automatic modulate_item(input logic [1:0] action, input logic [7:0] value);
      int             t;
      sample_exp_type e;
      case (action)
         ACT_LOAD: begin
            if (pkt_fill < BUF_DEPTH) begin
               pkt_mem[pkt_fill] = value;
               pkt_fill++;
            end
         end
         ACT_START: begin
            stage     = STG_START;
            bit_pos   = 0;
            bit_timer = 0;
            ones_run  = 0;
            tone      = 1'b0;
            next_frame_bit();
         end
         ACT_TICK: begin
            if (stage == STG_DONE) begin
               e.sample   = 8'd0;
               e.finished = 1'b1;
               due_samples.push_back(e);
            end else begin
               phase = phase + (tone ? cfg.phase_step_mark : cfg.phase_step_space);
               e.sample   = tone_sample(phase);
               e.finished = 1'b0;
               due_samples.push_back(e);
               t = bit_timer + int'(cfg.bit_step);
               if (t >= int'(cfg.sample_rate)) begin
                  t = t - int'(cfg.sample_rate);
                  // at most one bit per tick: drop the excess
                  if (t >= int'(cfg.sample_rate))
                     t = (cfg.sample_rate > 0) ? int'(cfg.sample_rate) - 1 : 0;
                  bit_timer = t;
                  next_frame_bit();
               end else begin
                  bit_timer = t;
               end
            end
         end
         default: ;
      endcase
   endtask

   // Driver: feed items, hold off for register writes until the block is quiet
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid  <= 1'b0;
         req_tdata   <= '0;
         req_tuser   <= '0;
         csr_psel    <= 1'b0;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b0;
         csr_paddr   <= '0;
         csr_pwdata  <= '0;
         drv_state   <= DRV_FETCH;
         quiet_count <= 0;
         stim_done   <= 1'b0;
         cfg         = '{8'd0, 8'd0, 16'd1200, 16'd9600, 8'd1, 8'd1};
         pkt_fill    = 0;
         stage       = STG_DONE;
         bit_pos     = 0;
         bit_timer   = 0;
         ones_run    = 0;
         tone        = 1'b0;
         phase       = 8'd0;
      end else begin
         case (drv_state)
            DRV_FETCH: begin
               slot_free = !req_tvalid;
               if (req_tvalid && req_tready) begin
                  modulate_item(cur_item.action, cur_item.byte_value);
                  accepted_items++;
                  slot_free = 1'b1;
               end
               if (slot_free && pending_items.size() != 0) begin
                  if (pending_items[0].kind == ENT_WRITE) begin
                     quiet_count <= 0;
                     drv_state   <= DRV_SETTLE;
                  end else if (calm || $urandom_range(99) >= IDLE_PCT) begin
                     cur_item = pending_items.pop_front();
                     req_tdata <= cur_item.byte_value;
                     req_tuser <= cur_item.action;
                     slot_free = 1'b0;
                  end
               end
               req_tvalid <= !slot_free;
               stim_done  <= slot_free && pending_items.size() == 0;
            end
            DRV_SETTLE: begin
               // wait for all samples, then let a start or bit step finish
               if (due_samples.size() != 0) begin
                  quiet_count <= 0;
               end else if (quiet_count < QUIET_CYCLES) begin
                  quiet_count <= quiet_count + 1;
               end else begin
                  wr_entry = pending_items.pop_front();
                  csr_psel    <= 1'b1;
                  csr_penable <= 1'b0;
                  csr_pwrite  <= 1'b1;
                  csr_paddr   <= {wr_entry.reg_idx, 2'b00};
                  csr_pwdata  <= wr_entry.value;
                  drv_state   <= DRV_WSETUP;
               end
            end
            DRV_WSETUP: begin
               csr_penable <= 1'b1;
               drv_state   <= DRV_WACCESS;
            end
            DRV_WACCESS: begin
               if (csr_pready) begin
                  case (wr_entry.reg_idx)
                     REG_SPACE:       cfg.phase_step_space = wr_entry.value[7:0];
                     REG_MARK:        cfg.phase_step_mark  = wr_entry.value[7:0];
                     REG_BIT_STEP:    cfg.bit_step         = wr_entry.value[15:0];
                     REG_SAMPLE_RATE: cfg.sample_rate      = wr_entry.value[15:0];
                     REG_START_FLAGS: cfg.start_flags      = wr_entry.value[7:0];
                     REG_END_FLAGS:   cfg.end_flags        = wr_entry.value[7:0];
                     default: ;
                  endcase
                  csr_penable <= 1'b0;
                  csr_pwrite  <= 1'b0;
                  drv_state   <= DRV_RSETUP;
               end
            end
            DRV_RSETUP: begin
               csr_penable <= 1'b1;
               drv_state   <= DRV_RACCESS;
            end
            DRV_RACCESS: begin
               // read back the register just written
               if (csr_pready) begin
                  if (csr_prdata !== wr_entry.value)
                     note_error($sformatf("register %0d readback: expected %h, got %h",
                                          wr_entry.reg_idx, wr_entry.value, csr_prdata));
                  csr_psel    <= 1'b0;
                  csr_penable <= 1'b0;
                  drv_state   <= DRV_FETCH;
               end
            end
            default: drv_state <= DRV_FETCH;
         endcase
      end
   end

   // Monitor: compare each accepted sample with the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_samples.size() == 0) begin
               note_error($sformatf("unexpected sample %0d finished %b",
                                    rsp_tdata, rsp_tuser));
            end else begin
               got_exp = due_samples.pop_front();
               if (rsp_tdata !== got_exp.sample)
                  note_error($sformatf("sample: expected %0d, got %0d",
                                       $signed(got_exp.sample), rsp_tdata));
               if (rsp_tuser !== got_exp.finished)
                  note_error($sformatf("finished: expected %b, got %b",
                                       got_exp.finished, rsp_tuser));
            end
         end
         rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic queue_item(input logic [1:0] action, input logic [7:0] value);
      entry_type e;
      e            = '0;
      e.kind       = ENT_ITEM;
      e.action     = action;
      e.byte_value = value;
      pending_items.push_back(e);
      if (action != ACT_NONE) item_total++;
   endtask

   task automatic queue_write(input logic [2:0] idx, input int value);
      entry_type e;
      e         = '0;
      e.kind    = ENT_WRITE;
      e.reg_idx = idx;
      e.value   = value;
      pending_items.push_back(e);
   endtask

   task automatic queue_setting(input int space, input int mark, input int br, input int sr,
                                input int sf, input int ef);
      queue_write(REG_SPACE, space);
      queue_write(REG_MARK, mark);
      queue_write(REG_BIT_STEP, br);
      queue_write(REG_SAMPLE_RATE, sr);
      queue_write(REG_START_FLAGS, sf);
      queue_write(REG_END_FLAGS, ef);
      plan_br = br;
      plan_sr = sr;
      plan_sf = sf;
      plan_ef = ef;
   endtask

   // Bias packet content toward long runs of ones and flag look-alikes
   function automatic logic [7:0] packet_byte();
      case ($urandom_range(7))
         0: return 8'hFF;
         1: return 8'h1F;
         2: return 8'hF8;
         3: return FLAG_BYTE;
         4: return 8'h00;
         default: return 8'($urandom);
      endcase
   endfunction

   // Load a packet, start it and tick through it; some frames are cut short
   task automatic queue_frame(input int nbytes, input int max_ticks, input int cut_pct);
      int k;
      int tpb;
      int bits;
      int ticks;
      for (k = 0; k < nbytes; k++) queue_item(ACT_LOAD, packet_byte());
      if ($urandom_range(99) < 5) queue_item(ACT_NONE, 8'($urandom));
      queue_item(ACT_START, 8'($urandom));
      plan_fill = (plan_fill + nbytes > BUF_DEPTH) ? BUF_DEPTH : plan_fill + nbytes;
      if (plan_br == 0) tpb = max_ticks;
      else if (plan_sr == 0) tpb = 1;
      else tpb = (plan_sr + plan_br - 1) / plan_br;
      bits  = (plan_sf + plan_ef) * 8 + plan_fill * 8 * 6 / 5 + 2;
      ticks = (bits * tpb > max_ticks) ? max_ticks : bits * tpb;
      ticks = ticks + $urandom_range(3);
      if ($urandom_range(99) < cut_pct) ticks = $urandom_range(ticks, 1);
      else plan_fill = 0;
      for (k = 0; k < ticks; k++) begin
         if ($urandom_range(99) < 4) queue_item(ACT_LOAD, packet_byte());
         else if ($urandom_range(99) < 2) queue_item(ACT_NONE, 8'($urandom));
         queue_item(ACT_TICK, 8'($urandom));
      end
   endtask

   task automatic queue_frames(input int budget, input int max_ticks);
      int stop_at;
      int nbytes;
      stop_at = item_total + budget;
      while (item_total < stop_at) begin
         nbytes = ($urandom_range(99) < 80) ? $urandom_range(6) : $urandom_range(24, 7);
         queue_frame(nbytes, max_ticks, 15);
      end
   endtask

   initial begin
      int k;
      int sr;
      int br;
      plan_br    = 1200;
      plan_sr    = 9600;
      plan_sf    = 1;
      plan_ef    = 1;
      plan_fill  = 0;
      item_total = 0;

      // Directed: idle tick at reset, ignored action, trailing ones stuffed,
      // empty start stage skipped, bit boundary on every tick
      queue_item(ACT_TICK, 8'h00);
      queue_setting(13, 255, 65535, 1, 0, 1);
      queue_item(ACT_NONE, 8'hAB);
      queue_item(ACT_LOAD, 8'hF8);
      queue_item(ACT_START, 8'h55);
      for (k = 0; k < 18; k++) queue_item(ACT_TICK, 8'hFF);

      // Random frames under a series of settings
      queue_setting(32, 64, 1200, 2400, 1, 1);
      queue_frames(50, 120);
      queue_setting(0, 255, 65535, 65535, 2, 0);
      queue_frames(50, 120);
      queue_setting(255, 0, 1, 3, 0, 2);
      queue_frames(50, 120);
      // fast bit rate with both flag stages empty
      queue_setting(17, 200, 65535, 1, 0, 0);
      queue_frames(40, 120);
      // zero bit rate: the frame never moves on
      queue_setting(9, 45, 0, 5, 1, 1);
      queue_frames(30, 12);
      // zero sample rate: every tick ends a bit
      queue_setting(77, 3, 7, 0, 1, 1);
      queue_frames(40, 120);
      // longest flag runs, frames get restarted long before the data
      queue_setting(128, 1, 65535, 65535, 255, 255);
      queue_frames(40, 60);
      for (k = 0; k < 3; k++) begin
         sr = $urandom_range(65535, 1);
         br = $urandom_range(sr, (sr + 2) / 3);
         queue_setting($urandom_range(255), $urandom_range(255), br, sr,
                       $urandom_range(3), $urandom_range(3));
         queue_frames(50, 120);
      end

      // Full buffer: extra loads are dropped, the first bytes stay intact
      queue_setting(31, 100, 100, 100, 0, 1);
      queue_frame(BUF_DEPTH + 4, 60, 0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (!stim_done) @(posedge clock);
      while (due_samples.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
